/* hdl/xor_nibble_id_cipher_top_assert.svh */
// Assertion macros shared by the cipher RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef XOR_NIBBLE_ID_CIPHER_TOP_ASSERT_SVH
`define XOR_NIBBLE_ID_CIPHER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define XNIC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define XNIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/xnic_pkg.sv */
// ----------------------------------------------------------------------------
// xnic_pkg
// Types, constants and helper functions of the XOR nibble identifier cipher.
// ----------------------------------------------------------------------------
package xnic_pkg;

    localparam int KEY_BYTES   = 8;
    localparam int MAX_RESULTS = 4;

    localparam logic [7:0] CHAR_A  = 8'd65;
    localparam logic [7:0] HI_MASK = 8'hF0;
    localparam logic [7:0] LO_MASK = 8'h0F;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY_KEY = 2'd1;
    localparam logic [1:0] ST_ODD_LEN   = 2'd2;
    localparam logic [1:0] ST_MISMATCH  = 2'd3;

    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_KEY_LEN   = 2'd1;
    localparam logic [1:0] CFG_KEY_BYTES = 2'd2;

    typedef struct packed {
        logic [7:0] in_value;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_value;
        logic       is_verdict;
        logic [1:0] status;
        logic       out_last;
    } t_out_item;

    typedef struct packed {
        logic        mode;
        logic [3:0]  key_len;
        logic [63:0] key_bytes;
    } t_cfg;

    typedef struct packed {
        logic [2:0]                      count;
        t_out_item [MAX_RESULTS-1:0]     items;
    } t_step;

    // Remainder of an 8-bit counter by a key length of 1 to 8. Non-power-of-two
    // lengths use a reciprocal multiply, exact over the whole 8-bit range.
    function automatic logic [2:0] f_mod_len(input logic [7:0] x, input logic [3:0] n);
        logic [16:0] prod;
        logic [7:0]  quo;
        logic [7:0]  rem;
        prod = '0;
        quo  = '0;
        rem  = '0;
        case (n)
            4'd1: rem = '0;
            4'd2: rem = {7'd0, x[0]};
            4'd4: rem = {6'd0, x[1:0]};
            4'd8: rem = {5'd0, x[2:0]};
            4'd3: begin
                prod = {9'd0, x} * 17'd171;
                quo  = 8'(prod >> 9);
                rem  = x - 8'(quo * 8'd3);
            end
            4'd5: begin
                prod = {9'd0, x} * 17'd205;
                quo  = 8'(prod >> 10);
                rem  = x - 8'(quo * 8'd5);
            end
            4'd6: begin
                prod = {9'd0, x} * 17'd171;
                quo  = 8'(prod >> 10);
                rem  = x - 8'(quo * 8'd6);
            end
            4'd7: begin
                prod = {9'd0, x} * 17'd293;
                quo  = 8'(prod >> 11);
                rem  = x - 8'(quo * 8'd7);
            end
            default: rem = '0;
        endcase
        return rem[2:0];
    endfunction

    function automatic t_out_item f_data(input logic [7:0] value, input logic last);
        t_out_item item;
        item.out_value  = value;
        item.is_verdict = 1'b0;
        item.status     = ST_OK;
        item.out_last   = last;
        return item;
    endfunction

    function automatic t_out_item f_verdict(input logic [1:0] status);
        t_out_item item;
        item.out_value  = '0;
        item.is_verdict = 1'b1;
        item.status     = status;
        item.out_last   = 1'b1;
        return item;
    endfunction

endpackage

/* hdl/xnic_engine.sv */
// ----------------------------------------------------------------------------
// xnic_engine
// Message state and the single-pass computation of the results of one item.
// ----------------------------------------------------------------------------
module xnic_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  xnic_pkg::t_in_item i_item,
    input  xnic_pkg::t_cfg    i_cfg,
    output xnic_pkg::t_step   o_step
);
    import xnic_pkg::*;

    logic [7:0] r_byte_count, n_byte_count;
    logic [7:0] r_running_sum, n_running_sum;
    logic [7:0] r_first_char, n_first_char;
    logic       r_pair_phase, n_pair_phase;
    logic [7:0] r_held_byte, n_held_byte;
    logic       r_held_valid, n_held_valid;

    logic [3:0] eff_len;
    logic [2:0] key_pos;
    logic [2:0] key_pos_next;
    logic [7:0] key_now;
    logic [7:0] key_next;

    assign eff_len = (i_cfg.key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : i_cfg.key_len;
    assign key_pos = f_mod_len(r_byte_count, eff_len);
    // The checksum byte of an encrypt message uses the key slot after this one.
    // The counter wraps at 256, so the slot is taken from the incremented counter.
    assign key_pos_next = f_mod_len(r_byte_count + 8'd1, eff_len);
    assign key_now  = i_cfg.key_bytes[{key_pos, 3'b000} +: 8];
    assign key_next = i_cfg.key_bytes[{key_pos_next, 3'b000} +: 8];

    always_comb begin
        logic [7:0] sum_in;
        logic [7:0] cipher;
        logic [7:0] cipher_sum;
        logic [7:0] hi_part;
        logic [7:0] lo_part;
        logic [7:0] decoded;
        logic [7:0] sum_dec;
        logic [2:0] k;
        logic       clear;

        sum_in     = r_running_sum + i_item.in_value;
        cipher     = (i_item.in_value ^ key_now) + r_byte_count;
        cipher_sum = (sum_in ^ key_next) + (r_byte_count + 8'd1);
        hi_part    = ((r_first_char - CHAR_A) & LO_MASK) << 4;
        lo_part    = i_item.in_value - CHAR_A;
        decoded    = ((hi_part | lo_part) - r_byte_count) ^ key_now;
        sum_dec    = r_held_valid ? r_running_sum + r_held_byte : r_running_sum;
        k          = '0;
        clear      = 1'b0;

        o_step       = '0;
        n_byte_count  = r_byte_count;
        n_running_sum = r_running_sum;
        n_first_char  = r_first_char;
        n_pair_phase  = r_pair_phase;
        n_held_byte   = r_held_byte;
        n_held_valid  = r_held_valid;

        if (eff_len == 4'd0) begin
            if (i_item.in_last) begin
                o_step.items[0] = f_verdict(ST_EMPTY_KEY);
                k     = 3'd1;
                clear = 1'b1;
            end
        end else if (i_cfg.mode == MODE_ENC) begin
            o_step.items[0] = f_data(CHAR_A + ((cipher & HI_MASK) >> 4), 1'b0);
            o_step.items[1] = f_data(CHAR_A + (cipher & LO_MASK), 1'b0);
            o_step.items[2] = f_data(CHAR_A + ((cipher_sum & HI_MASK) >> 4), 1'b0);
            o_step.items[3] = f_data(CHAR_A + (cipher_sum & LO_MASK), 1'b1);
            n_running_sum   = sum_in;
            n_byte_count    = r_byte_count + 8'd1;
            if (i_item.in_last) begin
                k     = 3'd4;
                clear = 1'b1;
            end else begin
                k = 3'd2;
            end
        end else if (!r_pair_phase) begin
            if (i_item.in_last) begin
                o_step.items[0] = f_verdict(ST_ODD_LEN);
                k     = 3'd1;
                clear = 1'b1;
            end else begin
                n_first_char = i_item.in_value;
                n_pair_phase = 1'b1;
            end
        end else begin
            // Second letter of a pair: release the byte decoded one pair ago.
            n_byte_count  = r_byte_count + 8'd1;
            n_pair_phase  = 1'b0;
            n_running_sum = sum_dec;
            n_held_byte   = decoded;
            n_held_valid  = 1'b1;
            if (r_held_valid) begin
                o_step.items[0] = f_data(r_held_byte, 1'b0);
                o_step.items[1] = f_verdict((sum_dec == decoded) ? ST_OK : ST_MISMATCH);
            end else begin
                o_step.items[0] = f_verdict((sum_dec == decoded) ? ST_OK : ST_MISMATCH);
            end
            k = {2'd0, r_held_valid} + {2'd0, i_item.in_last};
            clear = i_item.in_last;
        end

        if (clear) begin
            n_byte_count  = '0;
            n_running_sum = '0;
            n_first_char  = '0;
            n_pair_phase  = 1'b0;
            n_held_byte   = '0;
            n_held_valid  = 1'b0;
        end
        o_step.count = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= '0;
            r_running_sum <= '0;
            r_first_char  <= '0;
            r_pair_phase  <= 1'b0;
            r_held_byte   <= '0;
            r_held_valid  <= 1'b0;
        end else if (i_accept) begin
            r_byte_count  <= n_byte_count;
            r_running_sum <= n_running_sum;
            r_first_char  <= n_first_char;
            r_pair_phase  <= n_pair_phase;
            r_held_byte   <= n_held_byte;
            r_held_valid  <= n_held_valid;
        end
    end

endmodule

/* hdl/xor_nibble_id_cipher_top.sv */
// The first result of an item is registered and offered in the cycle after the item is accepted.
// Results leave one per cycle while i_out_stall is low; the input stalls until an item's
// results (encrypt 2, final encrypt byte 4, decrypt 0 to 2) have drained from the
// four-entry result queue; a new item enters as the last result drains.
// Reset (synchronous, active low) clears the config, message state and count, not the queue.
// ----------------------------------------------------------------------------
// xor_nibble_id_cipher_top
// Streaming XOR/nibble cipher with a configuration port and a result queue.
// ----------------------------------------------------------------------------
`include "xor_nibble_id_cipher_top_assert.svh"

module xor_nibble_id_cipher_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  xnic_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output xnic_pkg::t_out_item o_out_item
);
    import xnic_pkg::*;

    t_cfg r_cfg;
    t_step step;
    t_out_item [MAX_RESULTS-1:0] r_queue;
    logic [2:0] r_count;
    logic in_accept;
    logic out_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MODE:      r_cfg.mode      <= i_cfg_data[0];
                CFG_KEY_LEN:   r_cfg.key_len   <= i_cfg_data[3:0];
                CFG_KEY_BYTES: r_cfg.key_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign out_take    = (r_count != 3'd0) && !i_out_stall;
    // A new transaction is taken once the queue is empty or its last entry leaves.
    assign o_in_stall  = !((r_count == 3'd0) || ((r_count == 3'd1) && !i_out_stall));
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != 3'd0);
    assign o_out_item  = r_queue[0];

    xnic_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_item),
        .i_cfg    (r_cfg),
        .o_step   (step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_accept) begin
            r_count <= step.count;
        end else if (out_take) begin
            r_count <= r_count - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_queue <= step.items;
        end else if (out_take) begin
            r_queue <= {t_out_item'('0), r_queue[MAX_RESULTS-1:1]};
        end
    end

    `XNIC_ASSERT_NOW(a_accept_when_drained, in_accept, (r_count == 3'd0) || ((r_count == 3'd1) && out_take), "item accepted while results still queued")
    `XNIC_ASSERT_NOW(a_verdict_is_last, o_out_valid && o_out_item.is_verdict, o_out_item.out_last, "verdict result without last mark")
    `XNIC_ASSERT_NEXT(a_last_empties, out_take && o_out_item.out_last && !in_accept, !o_out_valid, "results remain after the last result of a message")

endmodule
